// ===== rtl/core/bft_pkg.sv =====
package bft_pkg;

	localparam int ALPHABET    = 32;
	localparam int COUNT_WIDTH = 32;
	localparam int IDX_W       = $clog2(ALPHABET);
	localparam int DEPTH       = ALPHABET * ALPHABET;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CODE_W      = 21;
	localparam int INDEX_W     = 5;
	localparam int OUT_W       = 32;
	localparam int FREQ_W      = 17;
	localparam int STEP_W      = $clog2(FREQ_W);

	localparam logic [CODE_W-1:0] BASE_RESET = CODE_W'(97);

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [CODE_W-1:0]      code_t;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic [CODE_W-1:0]  symbol;
		logic [INDEX_W-1:0] first_index;
		logic [INDEX_W-1:0] second_index;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0]  pair_count;
		logic [OUT_W-1:0]  pair_total;
		logic [FREQ_W-1:0] frequency;
		logic              no_pairs;
	} rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic logic [OUT_W-1:0] clip32(input count_t v);
		logic [63:0] w;
		w = 64'(v);
		if (w > 64'(32'hFFFF_FFFF)) begin
			return '1;
		end
		return w[OUT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/bigram_frequency_table_unit.sv =====
// A push is accepted every cycle unless stalled; its count is written in the next cycle.
// A read goes through the count memory read, the bit-serial divider for the Q1.16 frequency
// and the output register, in that order, before rsp_valid is raised.
// After a read nothing is accepted until the divider is idle again, later while rsp_stall holds.
// A clear writes zero to every memory row, one row per cycle, with no transaction accepted.
// Reset is asynchronous and active low; it starts the same clearing pass and sets base 97.
module bigram_frequency_table_unit
	import bft_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  code_t cfg_data,
	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	code_t  base_q;
	code_t  prev_q;
	logic   have_prev_q;
	count_t total_q;
	logic   push_s1;
	logic   rd_s1;
	logic   rng_ok_s1;
	addr_t  addr_s1;
	logic   fwd_s1;
	count_t fwd_data_s1;
	logic   clr_busy_q;
	addr_t  clr_ptr_q;
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	logic        req_acc;
	logic        is_push;
	logic        is_read;
	logic        is_clear;
	code_t       sym_off;
	code_t       prev_off;
	logic        sym_in;
	logic        prev_in;
	logic        pair_hit;
	logic        rng_ok;
	addr_t       push_addr;
	addr_t       read_addr;
	logic        mem_rd_en;
	addr_t       mem_rd_addr;
	count_t      mem_rd_data;
	count_t      mem_data_s1;
	count_t      inc_data;
	logic        wr_en;
	addr_t       wr_addr;
	count_t      wr_data;
	logic        div_take;
	div_status_t div_stat;
	count_t      div_cnt;
	count_t      div_tot;
	logic [FREQ_W-1:0] div_quo;

	always_comb begin
		req_acc   = req_valid && !req_stall;
		is_push   = (req.command == CMD_PUSH);
		is_read   = (req.command == CMD_READ);
		is_clear  = (req.command == CMD_CLEAR);
		sym_off   = req.symbol - base_q;
		prev_off  = prev_q - base_q;
		sym_in    = (req.symbol >= base_q) && (sym_off < CODE_W'(ALPHABET));
		prev_in   = (prev_q >= base_q) && (prev_off < CODE_W'(ALPHABET));
		pair_hit  = have_prev_q && sym_in && prev_in;
		rng_ok    = (32'(req.first_index) < ALPHABET) && (32'(req.second_index) < ALPHABET);
		push_addr = ADDR_W'(prev_off[IDX_W-1:0]) * ADDR_W'(ALPHABET)
			+ ADDR_W'(sym_off[IDX_W-1:0]);
		read_addr = ADDR_W'(req.first_index) * ADDR_W'(ALPHABET)
			+ ADDR_W'(req.second_index);
		mem_rd_en   = req_acc && ((is_push && pair_hit) || is_read);
		mem_rd_addr = is_read ? read_addr : push_addr;
		mem_data_s1 = fwd_s1 ? fwd_data_s1 : mem_rd_data;
		inc_data    = (mem_data_s1 == '1) ? mem_data_s1 : mem_data_s1 + COUNT_WIDTH'(1);
		wr_en       = clr_busy_q || push_s1;
		wr_addr     = clr_busy_q ? clr_ptr_q : addr_s1;
		wr_data     = clr_busy_q ? '0 : inc_data;
		div_take    = div_stat.done && (!rsp_valid_q || !rsp_stall);
		req_stall   = clr_busy_q || rd_s1 || div_stat.busy;
	end

	bft_count_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	bft_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rd_s1),
		.dividend (rng_ok_s1 ? mem_data_s1 : '0),
		.divisor  (total_q),
		.take     (div_take),
		.status   (div_stat),
		.count    (div_cnt),
		.total    (div_tot),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RESET;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			total_q     <= '0;
			push_s1     <= 1'b0;
			rd_s1       <= 1'b0;
			fwd_s1      <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_ptr_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			push_s1 <= req_acc && is_push && pair_hit;
			rd_s1   <= req_acc && is_read;
			fwd_s1  <= mem_rd_en && wr_en && (wr_addr == mem_rd_addr);
			if (clr_busy_q) begin
				clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
				if (clr_ptr_q == ADDR_W'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (req_acc && is_push) begin
				if (!have_prev_q) begin
					prev_q      <= req.symbol;
					have_prev_q <= 1'b1;
				end else if (sym_in) begin
					prev_q <= req.symbol;
					if (prev_in && total_q != '1) begin
						total_q <= total_q + COUNT_WIDTH'(1);
					end
				end
			end
			if (req_acc && is_clear) begin
				total_q     <= '0;
				prev_q      <= '0;
				have_prev_q <= 1'b0;
				clr_busy_q  <= 1'b1;
				clr_ptr_q   <= '0;
			end
			if (div_take) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			addr_s1   <= push_addr;
			rng_ok_s1 <= rng_ok;
		end
		fwd_data_s1 <= wr_data;
		if (div_take) begin
			rsp_q.pair_count <= clip32(div_cnt);
			rsp_q.pair_total <= clip32(div_tot);
			rsp_q.frequency  <= (div_tot == '0) ? '0 : div_quo;
			rsp_q.no_pairs   <= (div_tot == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(clr_busy_q && push_s1))
		else $error("Clearing pass and count update write in the same cycle.");

	a_read_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |=> div_stat.busy)
		else $error("A read did not start the divider.");

	a_count_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.pair_count <= rsp.pair_total))
		else $error("Pair count exceeds the pair total.");

	a_empty_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.no_pairs) |-> (rsp.frequency == '0))
		else $error("Empty table gives a nonzero frequency.");

endmodule

// ===== rtl/core/bft_count_ram.sv =====
module bft_count_ram
	import bft_pkg::*;
(
	input  logic   clk,
	input  logic   wr_en,
	input  addr_t  wr_addr,
	input  count_t wr_data,
	input  logic   rd_en,
	input  addr_t  rd_addr,
	output count_t rd_data
);

	count_t mem [DEPTH];
	count_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/bft_divider.sv =====
module bft_divider
	import bft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  count_t            dividend,
	input  count_t            divisor,
	input  logic              take,
	output div_status_t       status,
	output count_t            count,
	output count_t            total,
	output logic [FREQ_W-1:0] quotient
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [COUNT_WIDTH:0] rem_q;
	logic [FREQ_W-1:0]   quo_q;
	count_t              cnt_q;
	count_t              tot_q;

	logic [COUNT_WIDTH:0] trial;
	logic                 ge;

	always_comb begin
		trial = (step_q == '0) ? rem_q : {rem_q[COUNT_WIDTH-1:0], 1'b0};
		ge    = trial >= {1'b0, tot_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						step_q  <= '0;
						state_q <= (divisor == '0) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(FREQ_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cnt_q <= dividend;
			tot_q <= divisor;
			rem_q <= {1'b0, dividend};
			quo_q <= '0;
		end else if (state_q == ST_RUN) begin
			rem_q <= ge ? (trial - {1'b0, tot_q}) : trial;
			quo_q <= {quo_q[FREQ_W-2:0], ge};
		end
	end

	assign status.busy = (state_q != ST_IDLE);
	assign status.done = (state_q == ST_DONE);
	assign count       = cnt_q;
	assign total       = tot_q;
	assign quotient    = quo_q;

endmodule

// ===== test/bigram_frequency_table_unit_tb.sv =====
`timescale 1ns / 100ps

module bigram_frequency_table_unit_tb;
	import bft_pkg::*;

	localparam int          LIMIT_CYCLES = 600000;
	localparam int          NUM_PHASES   = 6;
	localparam int          PHASE_ITEMS  = 190;
	localparam int          SETTLE_WAIT  = 1100;
	localparam int          TAIL_WAIT    = 100;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;
	localparam code_t       BASE_TOP     = CODE_W'(1114111);
	localparam rsp_t        NO_RSP       = '0;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cfg_we    = 1'b0;
	code_t cfg_data  = '0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	count_t exp_counts [DEPTH];
	count_t exp_total;
	code_t  exp_prev;
	bit     exp_have_prev;
	code_t  exp_base;

	rsp_t pending_reads [$];
	int   errors        = 0;
	int   cycle_count   = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;

	bigram_frequency_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic bit in_alphabet(code_t c);
		int unsigned cv, bv;
		cv = c;
		bv = exp_base;
		return cv >= bv && (cv - bv) < ALPHABET;
	endfunction

	function automatic logic [OUT_W-1:0] saturate_out(count_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'(32'hFFFF_FFFF)) ? '1 : w[OUT_W-1:0];
	endfunction

	task automatic clear_expected();
		for (int k = 0; k < DEPTH; k++) begin
			exp_counts[k] = '0;
		end
		exp_total     = '0;
		exp_prev      = '0;
		exp_have_prev = 1'b0;
	endtask

	task automatic predict_bigram(input req_t it, output bit produced, output rsp_t r);
		int unsigned slot;
		count_t      cnt;
		logic [63:0] quot;
		produced = 1'b0;
		r        = '0;
		case (it.command)
			CMD_PUSH: begin
				if (!exp_have_prev) begin
					exp_prev      = it.symbol;
					exp_have_prev = 1'b1;
				end else if (in_alphabet(it.symbol)) begin
					if (in_alphabet(exp_prev)) begin
						slot = (int'(exp_prev) - int'(exp_base)) * ALPHABET
							+ (int'(it.symbol) - int'(exp_base));
						if (exp_counts[slot] != '1) begin
							exp_counts[slot] = exp_counts[slot] + 1'b1;
						end
						if (exp_total != '1) begin
							exp_total = exp_total + 1'b1;
						end
					end
					exp_prev = it.symbol;
				end
			end
			CMD_READ: begin
				cnt = '0;
				if (it.first_index < ALPHABET && it.second_index < ALPHABET) begin
					cnt = exp_counts[int'(it.first_index) * ALPHABET + int'(it.second_index)];
				end
				quot = '0;
				if (exp_total != '0) begin
					quot = (64'(cnt) << 16) / 64'(exp_total);
					if (quot > 64'd65536) begin
						quot = 64'd65536;
					end
				end
				produced     = 1'b1;
				r.pair_count = saturate_out(cnt);
				r.pair_total = saturate_out(exp_total);
				r.frequency  = quot[FREQ_W-1:0];
				r.no_pairs   = (exp_total == '0);
			end
			CMD_CLEAR: begin
				clear_expected();
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		errors++;
	endtask

	always @(posedge clk) begin
		rsp_t w;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_reads.size() == 0) begin
				flag_mismatch("unexpected transaction, pair_count", rsp.pair_count, 0);
			end else begin
				w = pending_reads.pop_front();
				if (rsp.pair_count !== w.pair_count)
					flag_mismatch("pair_count", rsp.pair_count, w.pair_count);
				if (rsp.pair_total !== w.pair_total)
					flag_mismatch("pair_total", rsp.pair_total, w.pair_total);
				if (rsp.frequency !== w.frequency)
					flag_mismatch("frequency", rsp.frequency, w.frequency);
				if (rsp.no_pairs !== w.no_pairs)
					flag_mismatch("no_pairs", rsp.no_pairs, w.no_pairs);
			end
		end
		rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	function automatic req_t push_req(code_t sym);
		req_t r;
		r              = '0;
		r.command      = CMD_PUSH;
		r.symbol       = sym;
		r.first_index  = 5'($urandom);
		r.second_index = 5'($urandom);
		return r;
	endfunction

	function automatic req_t read_req(int unsigned fi, int unsigned si);
		req_t r;
		r              = '0;
		r.command      = CMD_READ;
		r.symbol       = code_t'($urandom);
		r.first_index  = INDEX_W'(fi);
		r.second_index = INDEX_W'(si);
		return r;
	endfunction

	function automatic req_t other_req(cmd_t c);
		req_t r;
		r              = '0;
		r.command      = c;
		r.symbol       = code_t'($urandom);
		r.first_index  = 5'($urandom);
		r.second_index = 5'($urandom);
		return r;
	endfunction

	function automatic rsp_t typed_rsp(logic [31:0] c, logic [31:0] t, logic [16:0] f,
		logic n);
		rsp_t r;
		r.pair_count = c;
		r.pair_total = t;
		r.frequency  = f;
		r.no_pairs   = n;
		return r;
	endfunction

	function automatic int unsigned pick_index();
		return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 31);
	endfunction

	function automatic req_t random_request();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 2) return other_req(CMD_CLEAR);
		if (roll < 4) return other_req(cmd_t'(CMD_UNUSED));
		if (roll < 22) return read_req(pick_index(), pick_index());
		roll = $urandom_range(0, 99);
		if (roll < 80) return push_req(code_t'(int'(exp_base) + int'(pick_index())));
		if (roll < 90) return push_req(code_t'($urandom));
		if (roll < 95 && exp_base != '0) return push_req(exp_base - 1'b1);
		return push_req(code_t'(int'(exp_base) + ALPHABET));
	endfunction

	task automatic send_item(input req_t it, input bit typed, input rsp_t want);
		bit   produced;
		rsp_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_bigram(it, produced, r);
		if (produced) begin
			pending_reads.push_back(typed ? want : r);
		end
	endtask

	task automatic drain_reads();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0) @(posedge clk);
	endtask

	task automatic write_base(input code_t v);
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(posedge clk);
		exp_base = v;
		cfg_we   <= 1'b0;
	endtask

	initial begin
		dir_row_t dir_table [$];
		code_t    b;
		code_t    next_base;

		exp_base = BASE_RESET;
		clear_expected();
		b = BASE_RESET;

		dir_table = '{
			'{read_req(0, 0),                  1'b1, typed_rsp(0, 0, 0, 1'b1)},
			'{read_req(31, 31),                1'b1, typed_rsp(0, 0, 0, 1'b1)},
			'{push_req(21'h1FFFFF),            1'b0, NO_RSP},
			'{push_req(b),                     1'b0, NO_RSP},
			'{push_req(b + 21'd1),             1'b0, NO_RSP},
			'{read_req(0, 1),                  1'b1, typed_rsp(1, 1, 17'd65536, 1'b0)},
			'{read_req(1, 0),                  1'b1, typed_rsp(0, 1, 0, 1'b0)},
			'{push_req(21'd0),                 1'b0, NO_RSP},
			'{push_req(b + 21'd31),            1'b0, NO_RSP},
			'{read_req(1, 31),                 1'b0, NO_RSP},
			'{other_req(cmd_t'(CMD_UNUSED)),   1'b0, NO_RSP},
			'{push_req(b + 21'd30),            1'b0, NO_RSP},
			'{push_req(b - 21'd1),             1'b0, NO_RSP},
			'{push_req(b + 21'd32),            1'b0, NO_RSP},
			'{push_req(b),                     1'b0, NO_RSP},
			'{read_req(31, 30),                1'b0, NO_RSP},
			'{read_req(30, 0),                 1'b0, NO_RSP},
			'{other_req(CMD_CLEAR),            1'b0, NO_RSP},
			'{read_req(0, 1),                  1'b1, typed_rsp(0, 0, 0, 1'b1)},
			'{push_req(b + 21'd1),             1'b0, NO_RSP},
			'{push_req(b + 21'd1),             1'b0, NO_RSP},
			'{read_req(1, 1),                  1'b1, typed_rsp(1, 1, 17'd65536, 1'b0)},
			'{read_req(0, 0),                  1'b1, typed_rsp(0, 1, 0, 1'b0)}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 11;
		recv_idle_pct = 62;
		foreach (dir_table[i]) begin
			send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_reads();
			repeat (SETTLE_WAIT) @(posedge clk);
			case (p)
				0: next_base = '0;
				1: next_base = BASE_TOP;
				3: next_base = BASE_RESET;
				default: next_base = code_t'($urandom_range(0, 1114111));
			endcase
			write_base(next_base);
			if (p < 2) begin
				send_idle_pct = 11;
				recv_idle_pct = 62;
			end else if (p < 4) begin
				send_idle_pct = 62;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == 60) begin
					drain_reads();
				end
				send_item(random_request(), 1'b0, NO_RSP);
			end
		end

		drain_reads();
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0 && pending_reads.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bft_pkg.sv
rtl/core/bft_count_ram.sv
rtl/core/bft_divider.sv
rtl/core/bigram_frequency_table_unit.sv
test/bigram_frequency_table_unit_tb.sv
